// File: hdl/ddf_pkg.sv
package ddf_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HASH,
        PH_RUN0,
        PH_LIT,
        PH_DESC,
        PH_DROP
    } t_phase;

    // result kinds
    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_FRAG = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   byte_value;
        logic [63:0]  fingerprint;
        logic [31:0]  packet_hash;
        logic [15:0]  left_limit;
        logic [15:0]  right_limit;
        logic [15:0]  position;
        logic         status;
        logic         last;
    } t_rec;

    // records produced by one step, in order: rec0 first
    typedef struct packed {
        logic [1:0] n;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

    localparam logic [15:0] RUN_TO_END     = 16'hffff;
    localparam logic [15:0] DESC_BYTES     = 16'd18;
    localparam logic [15:0] HEADER_BYTES   = 16'd6;
    localparam logic [15:0] MAX_SIZE_RESET = 16'd1500;

    localparam logic [4:0] HASH_BYTES = 5'd4;
    localparam logic [4:0] RUN_BYTES  = 5'd2;

    // byte offsets inside a descriptor
    localparam logic [4:0] DESC_HASH_AT  = 5'd8;
    localparam logic [4:0] DESC_LEFT_AT  = 5'd12;
    localparam logic [4:0] DESC_RIGHT_AT = 5'd14;
    localparam logic [4:0] DESC_RIGHT_LO = 5'd15;
    localparam logic [4:0] DESC_RUN_AT   = 5'd16;
    localparam logic [4:0] DESC_RUN_LO   = 5'd17;

    // result queue, depth a power of two
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

endpackage

// File: hdl/dedup_packet_deframer.sv
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_stall  | data_byte, first_byte, packet_length
// out      | output    | o_out_valid / i_out_stall| kind, byte_value, fingerprint, packet_hash,
//          |           |                          | left_limit, right_limit, position, status, last
// cfg      | input     | i_cfg_we                 | max_packet_size
//
// one byte is taken per cycle while o_in_stall is low; a byte passes through the input
// register and the parser into the result queue, whose head shows on the out channel
// the rate is set by the out channel: one record per cycle unless stalled, so a byte that
// yields a record and an end record needs two transfers, absorbed by a four-entry queue
// synchronous active-low reset clears the parse state and the queue, and loads
// max_packet_size with 1500
// o_in_stall rises only when the input register holds a byte and the queue lacks room
// for two records
module dedup_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_packet_length,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [63:0] o_fingerprint,
    output logic [31:0] o_packet_hash,
    output logic [15:0] o_left_limit,
    output logic [15:0] o_right_limit,
    output logic [15:0] o_position,
    output logic        o_status,
    output logic        o_last
);
    import ddf_pkg::*;

    // max_packet_size register
    logic [15:0] r_max_size;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_data_byte;
    logic        r_first_byte;
    logic [15:0] r_packet_length;

    logic  room;
    logic  step;
    logic  in_xfer;
    t_push push;
    t_rec  out_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_max_size <= i_cfg_data;
        end
    end

    // the held byte moves into the parser when the queue can take its records
    assign step       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !step);
        end
    end

    // payload holds while stalled, loads on each input transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_data_byte     <= i_data_byte;
            r_first_byte    <= i_first_byte;
            r_packet_length <= i_packet_length;
        end
    end

    // parse state and record build for one byte
    ddf_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_data_byte     (r_data_byte),
        .i_first_byte    (r_first_byte),
        .i_packet_length (r_packet_length),
        .i_max_size      (r_max_size),
        .o_push          (push)
    );

    // result registers: up to two records written per byte, one read per transfer
    ddf_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_rec   (out_rec)
    );

    assign o_kind        = out_rec.kind;
    assign o_byte_value  = out_rec.byte_value;
    assign o_fingerprint = out_rec.fingerprint;
    assign o_packet_hash = out_rec.packet_hash;
    assign o_left_limit  = out_rec.left_limit;
    assign o_right_limit = out_rec.right_limit;
    assign o_position    = out_rec.position;
    assign o_status      = out_rec.status;
    assign o_last        = out_rec.last;

endmodule

// File: hdl/ddf_parser.sv
module ddf_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_data_byte,
    input  logic           i_first_byte,
    input  logic [15:0]    i_packet_length,
    input  logic [15:0]    i_max_size,
    output ddf_pkg::t_push o_push
);
    import ddf_pkg::*;

    t_phase       r_phase, n_phase;
    logic [15:0]  r_br, n_br;
    logic [4:0]   r_fbc, n_fbc;
    logic [15:0]  r_pos, n_pos;
    logic [15:0]  r_lit, n_lit;
    logic [31:0]  r_sent, n_sent;
    logic [63:0]  r_fp, n_fp;
    logic [31:0]  r_fhash, n_fhash;
    logic [15:0]  r_left, n_left;
    logic [15:0]  r_right, n_right;
    logic [15:0]  r_run, n_run;
    logic         r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_br    <= '0;
            r_fbc   <= '0;
            r_pos   <= '0;
            r_lit   <= '0;
            r_sent  <= '0;
            r_fp    <= '0;
            r_fhash <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_run   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_br    <= n_br;
            r_fbc   <= n_fbc;
            r_pos   <= n_pos;
            r_lit   <= n_lit;
            r_sent  <= n_sent;
            r_fp    <= n_fp;
            r_fhash <= n_fhash;
            r_left  <= n_left;
            r_right <= n_right;
            r_run   <= n_run;
            r_err   <= n_err;
        end
    end

    always_comb begin
        logic        active;
        logic        do_run;
        logic        do_desc;
        logic [15:0] run_len;
        logic [15:0] diff;
        logic [17:0] frag_end;
        t_rec        rec;

        n_phase = r_phase;
        n_br    = r_br;
        n_fbc   = r_fbc;
        n_pos   = r_pos;
        n_lit   = r_lit;
        n_sent  = r_sent;
        n_fp    = r_fp;
        n_fhash = r_fhash;
        n_left  = r_left;
        n_right = r_right;
        n_run   = r_run;
        n_err   = r_err;
        o_push  = '0;
        do_run  = 1'b0;
        do_desc = 1'b0;
        run_len = '0;
        diff    = '0;
        frag_end = '0;
        rec     = '0;

        active = i_step && (i_first_byte || (r_phase != PH_IDLE));

        // packet start, restarts a packet in flight
        if (i_step && i_first_byte) begin
            n_br    = i_packet_length;
            n_pos   = '0;
            n_fbc   = '0;
            n_lit   = '0;
            n_sent  = '0;
            n_run   = '0;
            n_err   = 1'b0;
            n_phase = PH_HASH;
            if (i_packet_length < HEADER_BYTES) begin
                n_err   = 1'b1;
                n_phase = PH_DROP;
            end
        end

        if (active) begin
            if (n_br != 16'd0) begin
                n_br = n_br - 16'd1;
            end

            unique case (n_phase)
                PH_HASH: begin
                    n_sent = {n_sent[23:0], i_data_byte};
                    n_fbc  = n_fbc + 5'd1;
                    if (n_fbc >= HASH_BYTES) begin
                        n_fbc   = '0;
                        n_run   = '0;
                        n_phase = PH_RUN0;
                    end
                end
                PH_RUN0: begin
                    n_run = {n_run[7:0], i_data_byte};
                    n_fbc = n_fbc + 5'd1;
                    if (n_fbc >= RUN_BYTES) begin
                        n_fbc = '0;
                        if (n_run > i_max_size || n_run > n_br) begin
                            n_err   = 1'b1;
                            n_phase = PH_DROP;
                        end else begin
                            do_run  = 1'b1;
                            run_len = n_run;
                        end
                    end
                end
                PH_LIT: begin
                    rec            = '0;
                    rec.kind       = KIND_LIT;
                    rec.byte_value = i_data_byte;
                    rec.position   = n_pos;
                    o_push.rec0    = rec;
                    o_push.n       = 2'd1;
                    n_pos = n_pos + 16'd1;
                    if (n_lit != 16'd0) begin
                        n_lit = n_lit - 16'd1;
                    end
                    if (n_lit == 16'd0) begin
                        do_desc = 1'b1;
                    end
                end
                PH_DESC: begin
                    if (n_fbc < DESC_HASH_AT) begin
                        n_fp = {n_fp[55:0], i_data_byte};
                    end else if (n_fbc < DESC_LEFT_AT) begin
                        n_fhash = {n_fhash[23:0], i_data_byte};
                    end else if (n_fbc < DESC_RIGHT_AT) begin
                        n_left = {n_left[7:0], i_data_byte};
                    end else if (n_fbc < DESC_RUN_AT) begin
                        n_right = {n_right[7:0], i_data_byte};
                    end else begin
                        n_run = {n_run[7:0], i_data_byte};
                    end

                    if (n_fbc == DESC_RIGHT_LO) begin
                        diff     = n_right - n_left;
                        frag_end = {2'b00, n_pos} + {2'b00, diff} + 18'd1;
                        if (n_left > n_right || frag_end > {2'b00, i_max_size}) begin
                            n_err   = 1'b1;
                            n_phase = PH_DROP;
                        end else begin
                            rec             = '0;
                            rec.kind        = KIND_FRAG;
                            rec.fingerprint = n_fp;
                            rec.packet_hash = n_fhash;
                            rec.left_limit  = n_left;
                            rec.right_limit = n_right;
                            rec.position    = n_pos;
                            o_push.rec0     = rec;
                            o_push.n        = 2'd1;
                            n_pos = frag_end[15:0];
                        end
                        n_fbc = n_fbc + 5'd1;
                    end else if (n_fbc == DESC_RUN_LO) begin
                        n_fbc = '0;
                        if (n_run == RUN_TO_END) begin
                            if ({1'b0, n_pos} + {1'b0, n_br} > {1'b0, i_max_size}) begin
                                n_err   = 1'b1;
                                n_phase = PH_DROP;
                            end else begin
                                do_run  = 1'b1;
                                run_len = n_br;
                            end
                        end else begin
                            if ({1'b0, n_pos} + {1'b0, n_run} > {1'b0, i_max_size}
                                || n_run > n_br) begin
                                n_err   = 1'b1;
                                n_phase = PH_DROP;
                            end else begin
                                do_run  = 1'b1;
                                run_len = n_run;
                            end
                        end
                    end else begin
                        n_fbc = n_fbc + 5'd1;
                    end
                end
                default: begin
                end
            endcase

            if (do_run) begin
                if (run_len != 16'd0) begin
                    n_lit   = run_len;
                    n_phase = PH_LIT;
                end else begin
                    do_desc = 1'b1;
                end
            end

            // fewer bytes left than a descriptor: drop them
            if (do_desc) begin
                if (n_br < DESC_BYTES) begin
                    n_phase = PH_DROP;
                end else begin
                    n_phase = PH_DESC;
                    n_fbc   = '0;
                end
            end

            // end record follows any record of this byte
            if (n_br == 16'd0) begin
                rec             = '0;
                rec.kind        = KIND_END;
                rec.packet_hash = n_sent;
                rec.position    = n_err ? 16'd0 : n_pos;
                rec.status      = n_err;
                rec.last        = 1'b1;
                if (o_push.n == 2'd0) begin
                    o_push.rec0 = rec;
                end else begin
                    o_push.rec1 = rec;
                end
                o_push.n = o_push.n + 2'd1;
                n_phase  = PH_IDLE;
                n_fbc    = '0;
                n_lit    = '0;
            end
        end
    end

endmodule

// File: hdl/ddf_out_queue.sv
module ddf_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ddf_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output ddf_pkg::t_rec  o_rec
);
    import ddf_pkg::*;

    t_rec             r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr, n_wr;
    logic [OQ_AW-1:0] r_rd, n_rd;
    logic [OQ_CW-1:0] r_count, n_count;
    logic             pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];
    // room for the two records one step can produce
    assign o_room  = (r_count <= OQ_CW'(OQ_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + OQ_AW'(i_push.n);
        n_rd    = r_rd + OQ_AW'(pop);
        n_count = r_count + OQ_CW'(i_push.n) - OQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + OQ_AW'(1)] <= i_push.rec1;
        end
    end

endmodule

// File: hdl/ddf_checker.sv
module ddf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_byte_value,
    input logic [63:0] o_fingerprint,
    input logic [31:0] o_packet_hash,
    input logic [15:0] o_left_limit,
    input logic [15:0] o_right_limit,
    input logic [15:0] o_position,
    input logic        o_status,
    input logic        o_last
);
    import ddf_pkg::*;

    // stalled record holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
        && $stable(o_byte_value) && $stable(o_fingerprint) && $stable(o_packet_hash)
        && $stable(o_left_limit) && $stable(o_right_limit) && $stable(o_position)
        && $stable(o_status) && $stable(o_last))
        else $error("stalled record changed");

    // last marks exactly the end record
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind == KIND_END)))
        else $error("last and kind disagree");

    // failed packet reports zero length
    a_err_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && o_status |-> (o_position == 16'd0))
        else $error("error end record with nonzero length");

    // literal and fragment records carry no status
    a_mid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_status)
        else $error("status on a non-end record");

endmodule

bind dedup_packet_deframer ddf_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_byte_value  (o_byte_value),
    .o_fingerprint (o_fingerprint),
    .o_packet_hash (o_packet_hash),
    .o_left_limit  (o_left_limit),
    .o_right_limit (o_right_limit),
    .o_position    (o_position),
    .o_status      (o_status),
    .o_last        (o_last)
);

// File: dv/ddf_record_checker.sv
`timescale 1ns / 1ps

module ddf_record_checker
    import ddf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_packet_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_byte_value,
    input  logic [63:0] i_fingerprint,
    input  logic [31:0] i_packet_hash,
    input  logic [15:0] i_left_limit,
    input  logic [15:0] i_right_limit,
    input  logic [15:0] i_position,
    input  logic        i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_bytes_taken,
    output int          o_lit_count,
    output int          o_frag_count,
    output int          o_end_count,
    output int          o_bad_end_count
);

    // parser mirror
    t_phase      phase;
    logic [15:0] max_size;
    logic [15:0] remain;
    logic [4:0]  fcount;
    logic [15:0] opos;
    logic [15:0] lit_left;
    logic [31:0] sent_h;
    logic [63:0] fp_sh;
    logic [31:0] frag_h;
    logic [15:0] left_v;
    logic [15:0] right_v;
    logic [15:0] run_v;
    logic        err;

    t_rec pending_records[$];

    int fails = 0;
    int waiting = 0;
    int bytes_taken = 0;
    int lit_cnt = 0;
    int frag_cnt = 0;
    int end_cnt = 0;
    int bad_end_cnt = 0;

    assign o_fail_count    = fails;
    assign o_pending       = waiting;
    assign o_bytes_taken   = bytes_taken;
    assign o_lit_count     = lit_cnt;
    assign o_frag_count    = frag_cnt;
    assign o_end_count     = end_cnt;
    assign o_bad_end_count = bad_end_cnt;

    function automatic t_rec make_record(t_kind k, logic [7:0] bv, logic [63:0] fp,
                                         logic [31:0] h, logic [15:0] l, logic [15:0] r,
                                         logic [15:0] pos, logic st, logic lst);
        t_rec rec;
        rec.kind        = k;
        rec.byte_value  = bv;
        rec.fingerprint = fp;
        rec.packet_hash = h;
        rec.left_limit  = l;
        rec.right_limit = r;
        rec.position    = pos;
        rec.status      = st;
        rec.last        = lst;
        return rec;
    endfunction

    function automatic logic over_limit(logic [31:0] amount);
        return ({16'd0, opos} + amount) > {16'd0, max_size};
    endfunction

    task automatic parse_error();
        err   = 1'b1;
        phase = PH_DROP;
    endtask

    task automatic open_descriptor();
        if (remain < DESC_BYTES) begin
            phase = PH_DROP;
        end else begin
            phase  = PH_DESC;
            fcount = 5'd0;
        end
    endtask

    task automatic open_run(logic [15:0] n);
        if (n != 16'd0) begin
            lit_left = n;
            phase    = PH_LIT;
        end else begin
            open_descriptor();
        end
    endtask

    // one accepted byte: advance the mirror, queue the records it yields
    task automatic parse_byte(logic [7:0] b, logic first, logic [15:0] len);
        logic [4:0]  c;
        logic [31:0] span;
        if (first) begin
            remain   = len;
            opos     = 16'd0;
            fcount   = 5'd0;
            lit_left = 16'd0;
            sent_h   = 32'd0;
            run_v    = 16'd0;
            err      = 1'b0;
            phase    = PH_HASH;
            if (remain < HEADER_BYTES)
                parse_error();
        end else if (phase == PH_IDLE) begin
            return;
        end
        if (remain != 16'd0)
            remain = remain - 16'd1;
        case (phase)
            PH_HASH: begin
                sent_h = {sent_h[23:0], b};
                fcount = fcount + 5'd1;
                if (fcount >= HASH_BYTES) begin
                    fcount = 5'd0;
                    run_v  = 16'd0;
                    phase  = PH_RUN0;
                end
            end
            PH_RUN0: begin
                run_v  = {run_v[7:0], b};
                fcount = fcount + 5'd1;
                if (fcount >= RUN_BYTES) begin
                    fcount = 5'd0;
                    if (run_v > max_size || run_v > remain)
                        parse_error();
                    else
                        open_run(run_v);
                end
            end
            PH_LIT: begin
                pending_records.push_back(make_record(KIND_LIT, b, 64'd0, 32'd0, 16'd0,
                                                      16'd0, opos, 1'b0, 1'b0));
                opos = opos + 16'd1;
                if (lit_left != 16'd0)
                    lit_left = lit_left - 16'd1;
                if (lit_left == 16'd0)
                    open_descriptor();
            end
            PH_DESC: begin
                c = fcount;
                if (c < DESC_HASH_AT)
                    fp_sh = {fp_sh[55:0], b};
                else if (c < DESC_LEFT_AT)
                    frag_h = {frag_h[23:0], b};
                else if (c < DESC_RIGHT_AT)
                    left_v = {left_v[7:0], b};
                else if (c < DESC_RUN_AT)
                    right_v = {right_v[7:0], b};
                else
                    run_v = {run_v[7:0], b};
                fcount = c + 5'd1;
                if (c == DESC_RIGHT_LO) begin
                    span = {16'd0, right_v} - {16'd0, left_v} + 32'd1;
                    if (left_v > right_v || over_limit(span)) begin
                        parse_error();
                    end else begin
                        pending_records.push_back(make_record(KIND_FRAG, 8'd0, fp_sh, frag_h,
                                                              left_v, right_v, opos,
                                                              1'b0, 1'b0));
                        opos = opos + span[15:0];
                    end
                end else if (c == DESC_RUN_LO) begin
                    fcount = 5'd0;
                    if (run_v == RUN_TO_END) begin
                        if (over_limit({16'd0, remain}))
                            parse_error();
                        else
                            open_run(remain);
                    end else if (over_limit({16'd0, run_v}) || run_v > remain) begin
                        parse_error();
                    end else begin
                        open_run(run_v);
                    end
                end
            end
            default: ;
        endcase
        if (remain == 16'd0) begin
            pending_records.push_back(make_record(KIND_END, 8'd0, 64'd0, sent_h, 16'd0, 16'd0,
                                                  err ? 16'd0 : opos, err, 1'b1));
            phase    = PH_IDLE;
            fcount   = 5'd0;
            lit_left = 16'd0;
        end
    endtask

    task automatic note_failure(string msg);
        if (fails < 10)
            $display("[%0t] %s", $realtime, msg);
        fails++;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            note_failure($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_rec want;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            max_size = MAX_SIZE_RESET;
            remain   = 16'd0;
            fcount   = 5'd0;
            opos     = 16'd0;
            lit_left = 16'd0;
            sent_h   = 32'd0;
            fp_sh    = 64'd0;
            frag_h   = 32'd0;
            left_v   = 16'd0;
            right_v  = 16'd0;
            run_v    = 16'd0;
            err      = 1'b0;
            pending_records.delete();
        end else begin
            // compare before predicting: a record never leaves in its byte's own cycle
            if (i_out_valid && !i_out_stall) begin
                if (pending_records.size() == 0) begin
                    note_failure($sformatf("record with no prediction: kind %0d position %0d",
                                           i_kind, i_position));
                end else begin
                    want = pending_records.pop_front();
                    check_field("kind", want.kind, i_kind);
                    check_field("byte_value", want.byte_value, i_byte_value);
                    check_field("fingerprint", want.fingerprint, i_fingerprint);
                    check_field("packet_hash", want.packet_hash, i_packet_hash);
                    check_field("left_limit", want.left_limit, i_left_limit);
                    check_field("right_limit", want.right_limit, i_right_limit);
                    check_field("position", want.position, i_position);
                    check_field("status", want.status, i_status);
                    check_field("last", want.last, i_last);
                    case (want.kind)
                        KIND_LIT:  lit_cnt++;
                        KIND_FRAG: frag_cnt++;
                        default: begin
                            end_cnt++;
                            if (want.status)
                                bad_end_cnt++;
                        end
                    endcase
                end
            end
            if (i_cfg_we)
                max_size = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                bytes_taken++;
                parse_byte(i_data_byte, i_first_byte, i_packet_length);
            end
        end
        waiting = pending_records.size();
    end

endmodule

// File: dv/tb_dedup_packet_deframer.sv
`timescale 1ns / 1ps

module tb_dedup_packet_deframer;
    import ddf_pkg::*;

    // run bounds, in clock cycles
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = 16'd0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_data = 8'd0;
    logic        in_first = 1'b0;
    logic [15:0] in_len = 16'd0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte_value;
    logic [63:0] out_fingerprint;
    logic [31:0] out_packet_hash;
    logic [15:0] out_left_limit;
    logic [15:0] out_right_limit;
    logic [15:0] out_position;
    logic        out_status;
    logic        out_last;

    // idle odds in percent, changed per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // long receiver hold-off to back the block up into its input
    logic hold_go = 1'b0;
    logic hold_off = 1'b0;

    int cycles = 0;

    int fail_count;
    int pending;
    int bytes_taken;
    int lit_count;
    int frag_count;
    int end_count;
    int bad_end_count;

    // bytes of the packet being built
    logic [7:0] pkt[$];

    dedup_packet_deframer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (in_data),
        .i_first_byte    (in_first),
        .i_packet_length (in_len),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (out_kind),
        .o_byte_value    (out_byte_value),
        .o_fingerprint   (out_fingerprint),
        .o_packet_hash   (out_packet_hash),
        .o_left_limit    (out_left_limit),
        .o_right_limit   (out_right_limit),
        .o_position      (out_position),
        .o_status        (out_status),
        .o_last          (out_last)
    );

    ddf_record_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_data_byte     (in_data),
        .i_first_byte    (in_first),
        .i_packet_length (in_len),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_kind          (out_kind),
        .i_byte_value    (out_byte_value),
        .i_fingerprint   (out_fingerprint),
        .i_packet_hash   (out_packet_hash),
        .i_left_limit    (out_left_limit),
        .i_right_limit   (out_right_limit),
        .i_position      (out_position),
        .i_status        (out_status),
        .i_last          (out_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_taken   (bytes_taken),
        .o_lit_count     (lit_count),
        .o_frag_count    (frag_count),
        .o_end_count     (end_count),
        .o_bad_end_count (bad_end_count)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("dedup_packet_deframer regression: fail");
            $finish;
        end
    end

    // receiver: random stall, forced high during the hold-off
    always @(posedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
    end

    // hold-off counted here while the sender keeps offering bytes
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // one byte transfer; returns at the accepting edge with valid still high
    task automatic send_byte(logic [7:0] b, logic first, logic [15:0] len);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_first <= first;
        in_len   <= len;
        do @(posedge clk); while (in_stall);
    endtask

    // register write, only while the block has nothing in flight
    task automatic write_max_size(logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // stop sending, wait for every predicted record, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_random(int n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    task automatic push_u16(logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    // build one packet: mostly well-formed, some with a wrong length, some with
    // out-of-range descriptor fields, some garbage, some stray bytes
    task automatic make_packet(output logic [15:0] len, output logic stray);
        int          mode;
        int          k;
        int          n;
        logic        bad;
        logic [15:0] run;
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] span;
        logic [15:0] tmp;
        pkt.delete();
        stray = 1'b0;
        mode  = $urandom_range(99);
        bad   = (mode >= 78 && mode < 85);
        if (mode >= 95) begin
            // bytes with no first-byte flag
            stray = 1'b1;
            n = $urandom_range(1, 4);
            push_random(n);
            len = 16'($urandom);
            return;
        end
        if (mode >= 85) begin
            // garbage body, length true or arbitrary
            n = $urandom_range(1, 30);
            push_random(n);
            len = $urandom_range(1) ? 16'(n) : 16'($urandom_range(0, 40));
            return;
        end
        push_random(4);
        run = 16'($urandom_range(0, 6));
        if (bad && $urandom_range(1))
            run = 16'($urandom);
        push_u16(run);
        push_random(run > 16'd8 ? 8 : int'(run));
        k = $urandom_range(0, 3);
        for (int d = 0; d < k; d++) begin
            // fingerprint and stored hash
            push_random(12);
            span = ($urandom_range(3) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            left = 16'($urandom_range(0, 65535 - int'(span)));
            right = left + span;
            if (bad && span != 16'd0 && $urandom_range(1)) begin
                tmp   = left;
                left  = right;
                right = tmp;
            end
            push_u16(left);
            push_u16(right);
            if (d == k - 1 && $urandom_range(1))
                run = RUN_TO_END;
            else
                run = 16'($urandom_range(0, 5));
            if (bad && $urandom_range(2) == 0)
                run = 16'($urandom);
            push_u16(run);
            if (run == RUN_TO_END) begin
                // literal tail to the end of the packet
                push_random($urandom_range(0, 5));
                break;
            end
            push_random(run > 16'd8 ? 8 : int'(run));
        end
        // short tail that can not hold a descriptor
        if ($urandom_range(4) == 0)
            push_random($urandom_range(1, 17));
        len = 16'(pkt.size());
        if (mode >= 70 && mode < 78) begin
            if ($urandom_range(1))
                len = len + 16'($urandom_range(1, 10));
            else if (len > 16'd10)
                len = len - 16'($urandom_range(1, 10));
            else
                len = 16'($urandom_range(0, 5));
        end
    endtask

    // random packets until about n_items packet bytes went in
    task automatic run_random(int n_items);
        int          items;
        logic [15:0] len;
        logic        stray;
        items = 0;
        while (items < n_items) begin
            make_packet(len, stray);
            for (int i = 0; i < pkt.size(); i++)
                send_byte(pkt[i], !stray && i == 0, (!stray && i == 0) ? len : 16'($urandom));
            if (!stray)
                items += pkt.size();
        end
    endtask

    initial begin
        // reset held from the start, then released and never asserted again
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset value of max_packet_size
        tx_idle_pct = 19;
        rx_idle_pct = 67;
        // stray byte while idle is ignored
        send_byte(8'hff, 1'b0, 16'hffff);
        // zero length acts as one byte: short header, ends at once
        send_byte(8'h00, 1'b1, 16'd0);
        // short header of three bytes
        send_byte(8'hff, 1'b1, 16'd3);
        send_byte(8'h00, 1'b0, 16'd0);
        send_byte(8'h5a, 1'b0, 16'd0);
        // longest length, then abandoned by a restart
        send_byte(8'h01, 1'b1, 16'hffff);
        send_byte(8'h02, 1'b0, 16'h0000);
        send_byte(8'h03, 1'b0, 16'hffff);
        send_byte(8'h04, 1'b0, 16'h0000);
        // restart: one literal on the last byte, so literal and end come together
        send_byte(8'hff, 1'b1, 16'd7);
        send_byte(8'hff, 1'b0, 16'd0);
        send_byte(8'hff, 1'b0, 16'd0);
        send_byte(8'hff, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0, 16'd0);
        send_byte(8'h01, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0, 16'd0);
        // header run longer than the bytes left
        send_byte(8'h12, 1'b1, 16'd6);
        send_byte(8'h34, 1'b0, 16'd0);
        send_byte(8'h56, 1'b0, 16'd0);
        send_byte(8'h78, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0, 16'd0);
        send_byte(8'h01, 1'b0, 16'd0);
        settle();

        // largest size, sender idles a little, receiver a lot
        write_max_size(16'hffff);
        run_random(700);
        settle();

        // smallest size: almost every run or fragment overflows
        write_max_size(16'd1);
        run_random(150);
        settle();

        // small size so fragments often overflow; idling swapped
        write_max_size(16'd300);
        tx_idle_pct = 67;
        rx_idle_pct = 19;
        run_random(650);
        settle();

        // random size, no idling, long receiver hold-off early on
        write_max_size(16'($urandom_range(40, 2000)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go = 1'b1;
        run_random(600);
        settle();

        $display("covered %0d input bytes under five size settings, with idle, stall and hold-off",
                 bytes_taken);
        $display("checked %0d literal and %0d fragment records, %0d packet ends (%0d in error)",
                 lit_count, frag_count, end_count, bad_end_count);
        if (fail_count == 0) begin
            $display("dedup_packet_deframer regression: pass");
        end else begin
            $display("dedup_packet_deframer regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ddf_pkg.sv
hdl/ddf_parser.sv
hdl/ddf_out_queue.sv
hdl/dedup_packet_deframer.sv
hdl/ddf_checker.sv
dv/ddf_record_checker.sv
dv/tb_dedup_packet_deframer.sv
